// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and codes of the task table scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TASK_INDEX_W = 5;

  typedef logic [TASK_INDEX_W-1:0] task_index_t;
  typedef logic [1:0]              status_t;
  typedef logic [7:0]              prio_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_SCHED  = 1'b1;

  typedef struct packed {
    logic  operation;
    prio_t task_priority;
  } req_t;

  typedef struct packed {
    status_t     status;
    task_index_t task_index;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic rd_cur;
    logic latch;
    logic scan;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rsp_valid;
    logic prio_start;
    logic hit;
    logic scan_end;
  } sts_t;

endpackage

// ===== rtl/task_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// task_table_scheduler
// Task slot allocator with round-robin or priority-scan selection.
// ----------------------------------------------------------------------------
// A create beat and a round-robin or empty-table schedule beat finish in the
// cycle they are accepted, so those items run at one per cycle as long as
// the response side keeps up. A priority-mode schedule beat walks the table
// through its single registered read port, one slot per cycle, and stops at
// the first qualifying slot; no new request is accepted until the scan
// ends. The response register frees the request side as soon as the
// pending response is taken. task_index carries the low five bits of the
// slot number.
module task_table_scheduler #(
  parameter int MAX_TASKS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tts_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tts_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  tts_pkg::cmd_t cmd;
  tts_pkg::sts_t sts;

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tts_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/tts_ctrl.sv =====
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: accepts request beats and steps the priority scan.
// ----------------------------------------------------------------------------
module tts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic          rsp_ready,
  input  tts_pkg::sts_t sts,
  output tts_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CUR   = 4'b0010,
    S_LATCH = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    req_ready  = (state == S_IDLE) && (!sts.rsp_valid || rsp_ready);
    cmd.take   = req_valid && req_ready;
    cmd.rd_cur = (state == S_CUR);
    cmd.latch  = (state == S_LATCH);
    cmd.scan   = (state == S_SCAN);
    cmd.finish = (state == S_SCAN) && (sts.hit || sts.scan_end);
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.take && sts.prio_start) state_next = S_CUR;
      end
      S_CUR:   state_next = S_LATCH;
      S_LATCH: state_next = S_SCAN;
      S_SCAN: begin
        if (cmd.finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/tts_datapath.sv =====
// ----------------------------------------------------------------------------
// tts_datapath
// Priority table, slot count, current task, scan pipeline and response reg.
// ----------------------------------------------------------------------------
module tts_datapath #(
  parameter int MAX_TASKS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  tts_pkg::req_t req,
  output tts_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  tts_pkg::cmd_t cmd,
  output tts_pkg::sts_t sts
);

  localparam int IDXW = $clog2(MAX_TASKS);
  localparam int CNTW = $clog2(MAX_TASKS + 1);

  tts_pkg::prio_t prio_mem [MAX_TASKS];
  tts_pkg::prio_t rd_data;
  tts_pkg::prio_t cur_prio;

  logic [CNTW-1:0] count;
  logic [IDXW-1:0] cur;
  logic            mode;
  logic [CNTW-1:0] scan_idx;
  logic [IDXW-1:0] chk_idx;
  logic            chk_valid;

  logic            full;
  logic            is_create;
  logic            scan_more;
  logic            rd_en;
  logic [IDXW-1:0] rd_addr;
  logic [CNTW-1:0] rr_step;
  logic [IDXW-1:0] rr_idx;
  logic            wr_en;
  logic            rsp_load;
  tts_pkg::rsp_t   rsp_next;
  logic            cur_load;
  logic [IDXW-1:0] cur_next;

  always_comb begin
    full      = (count == CNTW'(MAX_TASKS));
    is_create = (req.operation == tts_pkg::OP_CREATE);
    scan_more = (scan_idx < count);
    rr_step   = CNTW'(cur) + CNTW'(1);
    rr_idx    = (rr_step >= count) ? '0 : rr_step[IDXW-1:0];
    wr_en     = cmd.take && is_create && !full;

    rd_en = cmd.rd_cur || cmd.latch || (cmd.scan && scan_more);
    if (cmd.rd_cur) begin
      rd_addr = cur;
    end else if (cmd.latch) begin
      rd_addr = '0;
    end else begin
      rd_addr = scan_idx[IDXW-1:0];
    end

    sts.rsp_valid  = rsp_valid;
    sts.prio_start = !is_create && mode && (count != '0);
    sts.hit        = chk_valid && (chk_idx != cur) && (rd_data <= cur_prio);
    sts.scan_end   = !chk_valid;

    rsp_load            = 1'b0;
    rsp_next.status     = tts_pkg::ST_OK;
    rsp_next.task_index = '0;
    cur_load            = 1'b0;
    cur_next            = cur;
    if (cmd.take) begin
      if (is_create) begin
        rsp_load = 1'b1;
        if (full) begin
          rsp_next.status = tts_pkg::ST_FULL;
        end else begin
          rsp_next.task_index = tts_pkg::task_index_t'(count[IDXW-1:0]);
        end
      end else if (count == '0) begin
        rsp_load        = 1'b1;
        rsp_next.status = tts_pkg::ST_EMPTY;
      end else if (!mode) begin
        rsp_load            = 1'b1;
        rsp_next.task_index = tts_pkg::task_index_t'(rr_idx);
        cur_load            = 1'b1;
        cur_next            = rr_idx;
      end
    end else if (cmd.finish) begin
      rsp_load            = 1'b1;
      cur_load            = 1'b1;
      cur_next            = sts.hit ? chk_idx : cur;
      rsp_next.task_index = tts_pkg::task_index_t'(cur_next);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prio_mem[count[IDXW-1:0]] <= req.task_priority;
    end
    if (rd_en) begin
      rd_data <= prio_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_prio <= rd_data;
      chk_idx  <= '0;
      scan_idx <= CNTW'(1);
    end else if (cmd.scan && !cmd.finish && scan_more) begin
      chk_idx  <= scan_idx[IDXW-1:0];
      scan_idx <= scan_idx + CNTW'(1);
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cur       <= '0;
      mode      <= 1'b0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) mode <= cfg_wdata;
      if (wr_en) count <= count + CNTW'(1);
      if (cur_load) cur <= cur_next;
      if (cmd.latch) begin
        chk_valid <= 1'b1;
      end else if (cmd.finish) begin
        chk_valid <= 1'b0;
      end else if (cmd.scan) begin
        chk_valid <= scan_more;
      end
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (rsp_load) rsp_valid <= 1'b1;
    end
  end

endmodule

// ===== rtl/tts_checker.sv =====
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks of the task table scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tts_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input tts_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input tts_pkg::rsp_t rsp
);

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request beat changed while stalled");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == tts_pkg::ST_OK) || (rsp.status == tts_pkg::ST_FULL)
                  || (rsp.status == tts_pkg::ST_EMPTY))
    else $error("undefined status code");

  a_err_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != tts_pkg::ST_OK) |-> (rsp.task_index == '0))
    else $error("error response with nonzero task index");

  a_ready_gate: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rsp_valid || rsp_ready)
    else $error("request taken while response slot is blocked");

endmodule

bind task_table_scheduler tts_checker u_tts_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
